// ===== src/utf8cd_pkg.sv =====
// Shared types and constants for the UTF-8 codepoint decoder.
// No dependencies; imported by every module of the decoder.
package utf8cd_pkg;

    localparam int BYTE_W        = 8;
    localparam int CP_W          = 21;
    localparam int CP_TDATA_W    = 24;
    localparam int REP_W         = 2;
    localparam int QUEUE_DEPTH_D = 4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // One decoded byte's worth of output: rep replacement words,
    // then an optional tail word.
    typedef struct packed {
        logic [REP_W-1:0] rep;
        logic             has_tail;
        logic [CP_W-1:0]  tail_cp;
        logic             fin;
    } t_job;

endpackage

// ===== src/utf8cd_front.sv =====
// Front part of the decoder: accepts bytes, tracks the pending sequence
// and turns each byte into a job for the queue. Depends on utf8cd_pkg.
module utf8cd_front
    import utf8cd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_fin,
    input  logic              i_full,
    output logic              o_push,
    output t_job              o_job
);

    logic [CP_W-1:0]  r_partial, n_partial;
    logic [1:0]       r_needed,  n_needed;
    logic [1:0]       r_held,    n_held;

    logic             accept;
    logic             cont;
    logic [CP_W-1:0]  shifted;
    logic [1:0]       need_dec;
    logic [1:0]       held_inc;
    t_job             job;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign cont     = (i_byte[7:6] == 2'b10);
    assign shifted  = {r_partial[CP_W-7:0], i_byte[5:0]};
    assign need_dec = r_needed - 2'd1;
    assign held_inc = r_held + 2'd1;

    always_comb begin
        n_partial    = r_partial;
        n_needed     = r_needed;
        n_held       = r_held;
        job.rep      = '0;
        job.has_tail = 1'b0;
        job.tail_cp  = REPLACEMENT_CP;
        job.fin      = i_fin;
        if (r_needed != 2'd0 && cont) begin
            // continuation taken into the pending sequence
            if (need_dec == 2'd0) begin
                job.has_tail = (shifted != '0);
                job.tail_cp  = shifted;
                n_partial    = '0;
                n_needed     = 2'd0;
                n_held       = 2'd0;
            end else if (i_fin) begin
                job.rep   = held_inc + 2'd1;
                n_partial = '0;
                n_needed  = 2'd0;
                n_held    = 2'd0;
            end else begin
                n_partial = shifted;
                n_needed  = need_dec;
                n_held    = held_inc;
            end
        end else begin
            // drop a broken sequence, then handle the byte afresh
            if (r_needed != 2'd0) begin
                job.rep = r_held + 2'd1;
            end
            n_partial = '0;
            n_needed  = 2'd0;
            n_held    = 2'd0;
            if (i_byte[7] == 1'b0) begin
                job.has_tail = (i_byte != '0);
                job.tail_cp  = {{(CP_W-BYTE_W){1'b0}}, i_byte};
            end else if (i_byte[7:5] == 3'b110 || i_byte[7:4] == 4'b1110
                         || i_byte[7:3] == 5'b11110) begin
                if (i_fin) begin
                    job.has_tail = 1'b1;
                end else if (i_byte[5] == 1'b0) begin
                    n_partial = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                    n_needed  = 2'd1;
                end else if (i_byte[4] == 1'b0) begin
                    n_partial = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                    n_needed  = 2'd2;
                end else begin
                    n_partial = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                    n_needed  = 2'd3;
                end
            end else begin
                // stray continuation or invalid lead
                job.has_tail = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_needed  <= 2'd0;
            r_held    <= 2'd0;
        end else if (accept) begin
            r_partial <= n_partial;
            r_needed  <= n_needed;
            r_held    <= n_held;
        end
    end

    assign o_push = accept && (job.rep != '0 || job.has_tail);
    assign o_job  = job;

endmodule

// ===== src/utf8cd_queue.sv =====
// Short job queue between the decoder's front and back parts.
// Depends on utf8cd_pkg for the job type.
module utf8cd_queue
    import utf8cd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_D
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/utf8cd_back.sv =====
// Back part of the decoder: expands the head job into output words and
// holds them in the output register. Depends on utf8cd_pkg.
module utf8cd_back
    import utf8cd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_job            i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CP_W-1:0] o_cp,
    output logic            o_last,
    output logic            o_done
);

    logic [1:0]      r_idx;
    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_last;
    logic            r_done;

    logic            load;
    logic [2:0]      total;
    logic [2:0]      idx_next;
    logic            is_last;
    logic [CP_W-1:0] cur_cp;

    assign load     = i_valid && (!r_valid || i_ready);
    assign total    = {1'b0, i_head.rep} + {2'b00, i_head.has_tail};
    assign idx_next = {1'b0, r_idx} + 3'd1;
    assign is_last  = (idx_next == total);
    assign cur_cp   = (r_idx < i_head.rep) ? REPLACEMENT_CP : i_head.tail_cp;
    assign o_pop    = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= is_last ? 2'd0 : idx_next[1:0];
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= cur_cp;
            r_last <= is_last;
            r_done <= i_head.fin;
        end
    end

    assign o_valid = r_valid;
    assign o_cp    = r_cp;
    assign o_last  = r_last;
    assign o_done  = r_done;

endmodule

// ===== src/utf8_codepoint_decoder_top.sv =====
// UTF-8 codepoint decoder, top level. An accepted byte's job is registered in
// the job queue, then its words leave one at a time from the back part's output register.
// Throughput: one byte per cycle in while the queue is not full; one word per cycle
// out while m_axis_tready is high, so a byte that expands into more than one word holds
// the back part until its last word is taken, the job queue (QUEUE_DEPTH entries) absorbing the difference.
// Reset (i_rst_n low, synchronous) clears the pending sequence, queue and output.
module utf8_codepoint_decoder_top
    import utf8cd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] text_byte
    input  logic                  s_axis_tlast,   // final_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [CP_TDATA_W-1:0] m_axis_tdata,   // [20:0] codepoint, [23:21] zero
    output logic                  m_axis_tlast,   // last_of_run
    output logic                  m_axis_tuser    // text_done
);

    logic            push;
    t_job            job;
    logic            q_full;
    logic            q_valid;
    t_job            q_head;
    logic            pop;
    logic [CP_W-1:0] out_cp;

    // Front: classify each byte against the pending sequence, emit at most one job.
    utf8cd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_fin   (s_axis_tlast),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (job)
    );

    // Queue: decouple byte intake from word delivery.
    utf8cd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Back: expand the head job into replacement words and the tail word.
    utf8cd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (q_head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_cp    (out_cp),
        .o_last  (m_axis_tlast),
        .o_done  (m_axis_tuser)
    );

    // Pad the codepoint with zeros up to whole bytes.
    assign m_axis_tdata = {{(CP_TDATA_W-CP_W){1'b0}}, out_cp};

endmodule

// ===== src/utf8cd_checker.sv =====
// Port-level checks for the UTF-8 codepoint decoder, bound to its top level.
// Depends on utf8cd_pkg and utf8_codepoint_decoder_top.
module utf8cd_checker
    import utf8cd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [CP_TDATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tuser
);

    // Hold a stalled word unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // Zero-valued results are dropped and padding stays clear.
    a_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CP_W-1:0] != '0)
            && (m_axis_tdata[CP_TDATA_W-1:CP_W] == '0))
        else $error("zero codepoint or nonzero padding on output");

    // Nothing leaves the block in the cycle right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A word never appears without an earlier accepted byte behind it.
    a_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready)
            || $past(m_axis_tvalid) || $past(m_axis_tvalid, 2)
            || $past(s_axis_tvalid && s_axis_tready, 2)
            || !$past(m_axis_tvalid) && !$past(s_axis_tready))
        else $error("output word without a source byte");

endmodule

bind utf8_codepoint_decoder_top utf8cd_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
